// ===== hw/rtl/brae_pkg.sv =====
`timescale 1ns / 1ps
// shared opcodes, status codes and sequencer state type for the bytecode executor
// no dependencies

package brae_pkg;

  // instruction opcodes
  localparam logic [7:0] OP_ADD   = 8'h2B;
  localparam logic [7:0] OP_SUB   = 8'h2D;
  localparam logic [7:0] OP_MUL   = 8'h2A;
  localparam logic [7:0] OP_DIV   = 8'h2F;
  localparam logic [7:0] OP_MOD   = 8'h25;
  localparam logic [7:0] OP_LOAD  = 8'h24;
  localparam logic [7:0] OP_PRINT = 8'h3F;
  localparam logic [7:0] OP_HALT  = 8'h23;

  // result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_HALT    = 2'd3;

  // multiplier digit: bits of the second operand consumed per cycle
  localparam int MUL_DIGIT = 8;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

endpackage

// ===== hw/rtl/brae_ram.sv =====
`timescale 1ns / 1ps
// generic single-write, single-read synchronous ram with registered read data
// no dependencies

module brae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/bytecode_register_alu_executor.sv =====
`timescale 1ns / 1ps
// bytecode register alu executor: top level, register file in two mirrored rams
// depends on brae_pkg and brae_ram
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------------
//   in_     | input     | in_valid / in_stall | opcode, dest_index, src_a, src_b
//   out_    | output    | out_valid/out_stall | status, print_valid, print_index, print_value
//
// one item at a time: accept, operand read from the rams, execute, write back
// add, sub, load, print, halt, unknown and index errors go from execute straight to S_FIN
// mul steps through S_MUL (8-bit digit per cycle into the accumulator)
// div and mod step through S_DIV (restoring divider, one bit per cycle)
// reset clears the per-entry valid bits at once, an entry never written reads as zero
// a stalled result sits in the output register while the next item is accepted;
// write back and result load wait together in S_FIN while that register is full and stalled

module bytecode_register_alu_executor
  import brae_pkg::*;
#(
  parameter int REG_COUNT  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // instruction items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_opcode,
  input  logic [7:0]  in_dest_index,
  input  logic [7:0]  in_src_a,
  input  logic [7:0]  in_src_b,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_print_valid,
  output logic [3:0]  out_print_index,
  output logic [31:0] out_print_value
);

  localparam int AW        = $clog2(REG_COUNT);
  localparam int CW        = $clog2(DATA_WIDTH);
  localparam int MUL_STEPS = (DATA_WIDTH + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam logic [CW-1:0] MUL_LAST = CW'(MUL_STEPS - 1);
  localparam logic [CW-1:0] DIV_LAST = CW'(DATA_WIDTH - 1);

  // index check against the register count
  function automatic logic idx_ok(input logic [7:0] idx);
    return ({24'd0, idx} < 32'(REG_COUNT));
  endfunction

  // sequencer
  state_t state_r, state_nxt;

  // captured instruction
  logic [7:0] op_r, d_r, a_r, b_r;
  // valid bits of the two operands, read alongside the rams
  logic       va_r, vb_r;

  // shared datapath registers: operands, accumulator / remainder, step count
  logic [DATA_WIDTH-1:0] opa_r, opa_nxt;
  logic [DATA_WIDTH-1:0] opb_r, opb_nxt;
  logic [DATA_WIDTH-1:0] acc_r, acc_nxt;
  logic [DATA_WIDTH-1:0] res_r, res_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;

  // pending result and write back
  logic        wr_en_r, wr_en_nxt;
  logic [1:0]  status_r, status_nxt;
  logic        pv_r, pv_nxt;
  logic [31:0] pval_r, pval_nxt;

  // output register
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic        out_pv_r;
  logic [3:0]  out_pi_r;
  logic [31:0] out_pval_r;

  // register file valid bits, cleared by reset
  logic [REG_COUNT-1:0] valid_r;

  logic                  in_fire;
  logic                  out_load;
  logic                  ram_we;
  logic [AW-1:0]         rd_addr_a;
  logic [AW-1:0]         rd_addr_b;
  logic [DATA_WIDTH-1:0] rd_a, rd_b;
  logic [DATA_WIDTH-1:0] x, y;
  logic                  d_ok, a_ok, b_ok;
  logic [DATA_WIDTH+MUL_DIGIT-1:0] mul_part;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   trial_diff;
  logic [DATA_WIDTH-1:0] rem_step, quo_step, acc_step;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  assign ram_we   = out_load && wr_en_r;

  // port a serves the first source, or the register to print
  assign rd_addr_a = (in_opcode == OP_PRINT) ? in_dest_index[AW-1:0] : in_src_a[AW-1:0];
  assign rd_addr_b = in_src_b[AW-1:0];

  // two mirrored copies give two read ports
  brae_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (REG_COUNT)
  ) u_ram_a (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (d_r[AW-1:0]),
    .wr_data (res_r),
    .rd_en   (in_fire),
    .rd_addr (rd_addr_a),
    .rd_data (rd_a)
  );

  brae_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (REG_COUNT)
  ) u_ram_b (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (d_r[AW-1:0]),
    .wr_data (res_r),
    .rd_en   (in_fire),
    .rd_addr (rd_addr_b),
    .rd_data (rd_b)
  );

  // never-written entries read as zero
  assign x = va_r ? rd_a : '0;
  assign y = vb_r ? rd_b : '0;

  assign d_ok = idx_ok(d_r);
  assign a_ok = idx_ok(a_r);
  assign b_ok = idx_ok(b_r);

  // one multiplier digit per cycle
  assign mul_part = opa_r * opb_r[MUL_DIGIT-1:0];
  assign acc_step = acc_r + mul_part[DATA_WIDTH-1:0];

  // restoring divide step: remainder in acc_r, dividend/quotient in opa_r
  // a zero divisor always subtracts, giving all-ones quotient and the dividend back
  assign trial      = {acc_r, opa_r[DATA_WIDTH-1]};
  assign trial_diff = trial - {1'b0, opb_r};
  assign rem_step   = trial_diff[DATA_WIDTH] ? trial[DATA_WIDTH-1:0]
                                             : trial_diff[DATA_WIDTH-1:0];
  assign quo_step   = {opa_r[DATA_WIDTH-2:0], ~trial_diff[DATA_WIDTH]};

  always_comb begin
    state_nxt  = state_r;
    opa_nxt    = opa_r;
    opb_nxt    = opb_r;
    acc_nxt    = acc_r;
    res_nxt    = res_r;
    cnt_nxt    = cnt_r;
    wr_en_nxt  = wr_en_r;
    status_nxt = status_r;
    pv_nxt     = pv_r;
    pval_nxt   = pval_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt  = S_FIN;
        wr_en_nxt  = 1'b0;
        status_nxt = ST_DONE;
        pv_nxt     = 1'b0;
        pval_nxt   = '0;
        opa_nxt    = x;
        opb_nxt    = y;
        acc_nxt    = '0;
        cnt_nxt    = '0;
        case (op_r) inside
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
            if (!(d_ok && a_ok && b_ok)) begin
              status_nxt = ST_RANGE;
            end else begin
              wr_en_nxt = 1'b1;
              case (op_r)
                OP_ADD:  res_nxt = x + y;
                OP_SUB:  res_nxt = x - y;
                OP_MUL:  state_nxt = S_MUL;
                default: state_nxt = S_DIV;
              endcase
            end
          end
          OP_LOAD: begin
            if (!d_ok) begin
              status_nxt = ST_RANGE;
            end else begin
              wr_en_nxt = 1'b1;
              res_nxt   = DATA_WIDTH'(a_r);
            end
          end
          OP_PRINT: begin
            if (!d_ok) begin
              status_nxt = ST_RANGE;
            end else begin
              pv_nxt   = 1'b1;
              pval_nxt = 32'(x);
            end
          end
          OP_HALT: begin
            status_nxt = ST_HALT;
          end
          default: begin
            status_nxt = ST_UNKNOWN;
          end
        endcase
      end
      S_MUL: begin
        acc_nxt = acc_step;
        opa_nxt = opa_r << MUL_DIGIT;
        opb_nxt = opb_r >> MUL_DIGIT;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == MUL_LAST) begin
          res_nxt   = acc_step;
          state_nxt = S_FIN;
        end
      end
      S_DIV: begin
        acc_nxt = rem_step;
        opa_nxt = quo_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          res_nxt   = (op_r == OP_DIV) ? quo_step : rem_step;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (ram_we) begin
        valid_r[d_r[AW-1:0]] <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= in_opcode;
      d_r  <= in_dest_index;
      a_r  <= in_src_a;
      b_r  <= in_src_b;
      va_r <= valid_r[rd_addr_a];
      vb_r <= valid_r[rd_addr_b];
    end
    opa_r    <= opa_nxt;
    opb_r    <= opb_nxt;
    acc_r    <= acc_nxt;
    res_r    <= res_nxt;
    cnt_r    <= cnt_nxt;
    wr_en_r  <= wr_en_nxt;
    status_r <= status_nxt;
    pv_r     <= pv_nxt;
    pval_r   <= pval_nxt;
    if (out_load) begin
      out_status_r <= status_r;
      out_pv_r     <= pv_r;
      out_pi_r     <= pv_r ? d_r[3:0] : 4'd0;
      out_pval_r   <= pval_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_print_valid = out_pv_r;
  assign out_print_index = out_pi_r;
  assign out_print_value = out_pval_r;

  // an accepted item always goes to execute next
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_EXEC))
    else $error("accepted item did not enter execute");

  // a result only appears after the finish state
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result appeared outside the finish state");

  // the multiplier leaves only after its last digit
  a_mul_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL && state_nxt == S_FIN) |-> (cnt_r == MUL_LAST))
    else $error("multiply left early");

  // a reported print always carries done status; no print means zero fields
  a_print_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pv_r ? (out_status_r == ST_DONE)
                              : (out_pi_r == 4'd0 && out_pval_r == 32'd0)))
    else $error("print fields inconsistent with status");

endmodule

// ===== tb/tb_bytecode_register_alu_executor.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the bytecode register alu executor: directed and random
// instruction items, a shadow register file predicts every result item
// depends on brae_pkg and the executor rtl

module tb_bytecode_register_alu_executor;
  import brae_pkg::*;

  localparam int NUM_REGS     = 16;
  localparam int RANDOM_ITEMS = 1450;
  // rough total, directed items included, split into three idling phases
  localparam int PHASE_LEN    = 495;
  // longest item is div or mod: the divider steps plus the output register
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_AT      = 120;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct {
    logic [7:0] opcode;
    logic [7:0] dest;
    logic [7:0] src_a;
    logic [7:0] src_b;
    bit         drain_first;  // sender waits until no result is outstanding
  } instr_t;

  typedef struct {
    logic [1:0]  status;
    logic        print_valid;
    logic [3:0]  print_index;
    logic [31:0] print_value;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_opcode = '0;
  logic [7:0]  in_dest_index = '0;
  logic [7:0]  in_src_a = '0;
  logic [7:0]  in_src_b = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic        out_print_valid;
  logic [3:0]  out_print_index;
  logic [31:0] out_print_value;

  // shadow register file and bookkeeping
  logic [31:0] gpr [NUM_REGS];
  instr_t      pending_instrs[$];
  result_t     expected_results[$];
  instr_t      cur_instr;
  int          n_accepted = 0;
  int          n_results = 0;
  int          n_errors = 0;
  int          n_cycles = 0;
  int          n_arith = 0, n_load = 0, n_print = 0, n_halt = 0;
  int          n_unknown = 0, n_range = 0, n_divzero = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  bytecode_register_alu_executor u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_dest_index   (in_dest_index),
    .in_src_a        (in_src_a),
    .in_src_b        (in_src_b),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_print_valid (out_print_valid),
    .out_print_index (out_print_index),
    .out_print_value (out_print_value)
  );

  always #5 clk = ~clk;

  // executes one instruction on the shadow file, returns the result item it should give
  function automatic result_t execute_instruction(input instr_t ins);
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] r;
    result_t     res;
    res = '{ST_DONE, 1'b0, 4'd0, 32'd0};
    case (ins.opcode)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
        if (ins.dest >= NUM_REGS || ins.src_a >= NUM_REGS || ins.src_b >= NUM_REGS) begin
          res.status = ST_RANGE;
          n_range++;
        end else begin
          // both sources read before the write, so dest may alias a source
          x = gpr[ins.src_a[3:0]];
          y = gpr[ins.src_b[3:0]];
          case (ins.opcode)
            OP_ADD: r = x + y;
            OP_SUB: r = x - y;
            OP_MUL: r = x * y;
            OP_DIV: begin
              // divide by zero gives all ones
              r = (y == 32'd0) ? '1 : x / y;
              if (y == 32'd0) n_divzero++;
            end
            default: begin
              // modulo by zero leaves the dividend
              r = (y == 32'd0) ? x : x % y;
              if (y == 32'd0) n_divzero++;
            end
          endcase
          gpr[ins.dest[3:0]] = r;
          n_arith++;
        end
      end
      OP_LOAD: begin
        if (ins.dest >= NUM_REGS) begin
          res.status = ST_RANGE;
          n_range++;
        end else begin
          gpr[ins.dest[3:0]] = {24'd0, ins.src_a};
          n_load++;
        end
      end
      OP_PRINT: begin
        if (ins.dest >= NUM_REGS) begin
          res.status = ST_RANGE;
          n_range++;
        end else begin
          res.print_valid = 1'b1;
          res.print_index = ins.dest[3:0];
          res.print_value = gpr[ins.dest[3:0]];
          n_print++;
        end
      end
      OP_HALT: begin
        // no halted state is kept, later items run normally
        res.status = ST_HALT;
        n_halt++;
      end
      default: begin
        res.status = ST_UNKNOWN;
        n_unknown++;
      end
    endcase
    return res;
  endfunction

  task automatic add_instr(input logic [7:0] op, input logic [7:0] d, input logic [7:0] a,
                           input logic [7:0] b, input bit drain);
    pending_instrs.push_back('{op, d, a, b, drain});
  endtask

  function automatic logic [7:0] arith_op();
    case ($urandom_range(0, 4))
      0: return OP_ADD;
      1: return OP_SUB;
      2: return OP_MUL;
      3: return OP_DIV;
      default: return OP_MOD;
    endcase
  endfunction

  // mostly well-formed instructions on a live register file, some noise
  function automatic instr_t random_instr();
    instr_t ins;
    int     pick;
    ins.opcode = arith_op();
    ins.dest = 8'($urandom_range(0, NUM_REGS - 1));
    ins.src_a = 8'($urandom_range(0, NUM_REGS - 1));
    ins.src_b = 8'($urandom_range(0, NUM_REGS - 1));
    ins.drain_first = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      // any opcode byte, any field bytes
      ins.opcode = 8'($urandom_range(0, 255));
      ins.dest = 8'($urandom_range(0, 255));
      ins.src_a = 8'($urandom_range(0, 255));
      ins.src_b = 8'($urandom_range(0, 255));
    end else if (pick < 16) begin
      // one index past the register file
      case ($urandom_range(0, 4))
        0: ins.dest = 8'($urandom_range(NUM_REGS, 255));
        1: ins.src_a = 8'($urandom_range(NUM_REGS, 255));
        2: ins.src_b = 8'($urandom_range(NUM_REGS, 255));
        3: begin
          ins.opcode = OP_LOAD;
          ins.dest = 8'($urandom_range(NUM_REGS, 255));
          ins.src_a = 8'($urandom_range(0, 255));
        end
        default: begin
          ins.opcode = OP_PRINT;
          ins.dest = 8'($urandom_range(NUM_REGS, 255));
        end
      endcase
    end else if (pick < 36) begin
      ins.opcode = OP_LOAD;
      // small and zero immediates keep divide by zero and short quotients coming
      ins.src_a = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
      ins.src_b = 8'($urandom_range(0, 255));
    end else if (pick < 49) begin
      ins.opcode = OP_PRINT;
      ins.src_a = 8'($urandom_range(0, 255));
      ins.src_b = 8'($urandom_range(0, 255));
    end else if (pick < 52) begin
      ins.opcode = OP_HALT;
      ins.dest = 8'($urandom_range(0, 255));
      ins.src_a = 8'($urandom_range(0, 255));
      ins.src_b = 8'($urandom_range(0, 255));
    end
    return ins;
  endfunction

  // idling per phase: sender 34 / receiver 67, then swapped, then none
  function automatic int sender_idle_pct(input int n);
    if (n < PHASE_LEN) return 34;
    if (n < 2 * PHASE_LEN) return 67;
    return 0;
  endfunction

  function automatic int receiver_idle_pct(input int n);
    if (n < PHASE_LEN) return 67;
    if (n < 2 * PHASE_LEN) return 34;
    return 0;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_val,
               act_val);
      n_errors++;
    end
  endtask

  // driver: offers the head of the pending queue, predicts on acceptance
  always @(posedge clk) begin : driver
    logic nxt_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && !in_stall) begin
        expected_results.push_back(execute_instruction(cur_instr));
        n_accepted++;
        nxt_valid = 1'b0;
      end
      // a payload on hold stays put; a new item only goes out once the last is taken
      if (!nxt_valid && pending_instrs.size() > 0) begin
        if (pending_instrs[0].drain_first && expected_results.size() != 0) begin
          // pause until every outstanding result is back
        end else if ($urandom_range(0, 99) >= sender_idle_pct(n_accepted)) begin
          cur_instr = pending_instrs.pop_front();
          nxt_valid = 1'b1;
          in_opcode <= cur_instr.opcode;
          in_dest_index <= cur_instr.dest;
          in_src_a <= cur_instr.src_a;
          in_src_b <= cur_instr.src_b;
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // monitor: compares each result item with the oldest prediction, drives the stall
  always @(posedge clk) begin : monitor
    result_t exp_res;
    logic    nxt_stall;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d", $time,
                   out_status);
          n_errors++;
        end else begin
          exp_res = expected_results.pop_front();
          check_field("status", 32'(exp_res.status), 32'(out_status));
          check_field("print_valid", 32'(exp_res.print_valid), 32'(out_print_valid));
          check_field("print_index", 32'(exp_res.print_index), 32'(out_print_index));
          check_field("print_value", exp_res.print_value, out_print_value);
        end
      end
      // one long hold-off so the block backs up and stalls its input
      if (hold_left > 0) begin
        hold_left--;
        nxt_stall = 1'b1;
      end else if (!hold_done && n_results >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        nxt_stall = 1'b1;
      end else begin
        nxt_stall = ($urandom_range(0, 99) < receiver_idle_pct(n_results));
      end
      out_stall <= nxt_stall;
    end
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, n_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    instr_t ins;
    for (int i = 0; i < NUM_REGS; i++) gpr[i] = 32'd0;

    // directed: immediate extremes, every operation, wraparound, aliasing
    add_instr(OP_PRINT, 8'd15, 8'd0, 8'd0, 1'b0);     // reset value
    add_instr(OP_LOAD, 8'd1, 8'hFF, 8'd0, 1'b0);
    add_instr(OP_LOAD, 8'd2, 8'd1, 8'd0, 1'b0);
    add_instr(OP_LOAD, 8'd15, 8'd0, 8'd0, 1'b0);
    add_instr(OP_LOAD, 8'd3, 8'd7, 8'd0, 1'b0);
    add_instr(OP_ADD, 8'd4, 8'd1, 8'd2, 1'b0);
    add_instr(OP_SUB, 8'd5, 8'd15, 8'd2, 1'b0);       // 0 - 1 wraps to all ones
    add_instr(OP_ADD, 8'd6, 8'd5, 8'd2, 1'b0);        // carry out lost
    add_instr(OP_MUL, 8'd7, 8'd5, 8'd5, 1'b0);        // low word of the product only
    add_instr(OP_DIV, 8'd8, 8'd5, 8'd3, 1'b0);
    add_instr(OP_MOD, 8'd9, 8'd5, 8'd3, 1'b0);
    add_instr(OP_DIV, 8'd10, 8'd1, 8'd15, 1'b0);      // divide by zero
    add_instr(OP_MOD, 8'd11, 8'd1, 8'd15, 1'b0);      // modulo by zero
    add_instr(OP_MUL, 8'd1, 8'd1, 8'd1, 1'b0);        // dest aliases both sources
    add_instr(OP_PRINT, 8'd1, 8'd0, 8'd0, 1'b0);
    add_instr(OP_PRINT, 8'd5, 8'hFF, 8'hFF, 1'b0);
    add_instr(OP_PRINT, 8'd10, 8'd0, 8'd0, 1'b0);
    add_instr(OP_HALT, 8'hFF, 8'hFF, 8'hFF, 1'b0);    // halt checks no index
    add_instr(OP_PRINT, 8'd11, 8'd0, 8'd0, 1'b0);     // still running after halt
    add_instr(8'h00, 8'd0, 8'd0, 8'd0, 1'b0);         // unknown opcodes
    add_instr(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    add_instr(OP_LOAD, 8'd16, 8'hAA, 8'd0, 1'b0);     // indices out of range
    add_instr(OP_ADD, 8'd0, 8'd1, 8'hFF, 1'b0);
    add_instr(OP_DIV, 8'd0, 8'd16, 8'd3, 1'b0);
    add_instr(OP_PRINT, 8'hFF, 8'd0, 8'd0, 1'b0);

    // random part, with an occasional full drain before an item
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      ins = random_instr();
      ins.drain_first = (i % 300 == 0);
      pending_instrs.push_back(ins);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_instrs.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      $display("%0t: %0d results missing, expected status %0d first, actual none", $time,
               expected_results.size(), expected_results[0].status);
      n_errors++;
    end

    $display("ran %0d items in %0d cycles: %0d arithmetic (%0d by zero), %0d loads,",
             n_accepted, n_cycles, n_arith, n_divzero, n_load);
    $display("  %0d prints, %0d halts, %0d unknown opcodes, %0d index errors, %0d errors",
             n_print, n_halt, n_unknown, n_range, n_errors);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/brae_pkg.sv
hw/rtl/brae_ram.sv
hw/rtl/bytecode_register_alu_executor.sv
tb/tb_bytecode_register_alu_executor.sv
